/* rtl/wu256_pkg.sv */
// Shared types and constants for the wide unsigned ALU.
package wu256_pkg;

  localparam int unsigned OPCODE_W = 5;
  localparam int unsigned LIMB_W   = 64;
  localparam int unsigned NLIMBS   = 4;

  typedef enum logic [4:0] {
    OP_AND = 5'd0, OP_OR = 5'd1, OP_XOR = 5'd2, OP_NOT = 5'd3,
    OP_SHL = 5'd4, OP_SHR = 5'd5, OP_ADD = 5'd6, OP_SUB = 5'd7,
    OP_MUL = 5'd8, OP_DIV = 5'd9, OP_MOD = 5'd10, OP_EQ = 5'd11,
    OP_NE = 5'd12, OP_GT = 5'd13, OP_LT = 5'd14, OP_GE = 5'd15,
    OP_LE = 5'd16, OP_BITLEN = 5'd17
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_ITER, ST_FINISH, ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture operands
    logic init;    // clear iteration state, pick operation class
    logic step;    // one iteration of the multiply/divide loop
    logic finish;  // form the result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic iterative; // operation needs the step loop
    logic last;      // final step being taken
  } dp_stat_t;

endpackage

/* rtl/wu256_datapath.sv */
// Datapath: operand registers, add/sub, serial divider, shift-add multiplier.
module wu256_datapath
  import wu256_pkg::*;
#(
  parameter int unsigned WORD_BITS = 256
) (
  input  logic                  clk,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  input  logic [OPCODE_W-1:0]   in_opcode,
  input  logic [NLIMBS*LIMB_W-1:0] in_a,
  input  logic [NLIMBS*LIMB_W-1:0] in_b,
  output logic [NLIMBS*LIMB_W-1:0] res,
  output logic                  cmp_res,
  output logic                  dz_res
);

  localparam int unsigned CNT_W = $clog2(WORD_BITS + 1);
  localparam int unsigned OUT_W = NLIMBS * LIMB_W;

  logic [OPCODE_W-1:0]  op_r;
  logic [WORD_BITS-1:0] a_r, b_r, acc_r, acc_nxt, rem_r, rem_nxt;
  logic [WORD_BITS-1:0] q_r, q_nxt;
  logic [CNT_W-1:0]     cnt_r;
  logic [OUT_W-1:0]     res_r;
  logic                 cmp_r, dz_r;

  // divider step: shift remainder in, trial subtract
  logic [WORD_BITS:0] rem_sh, trial;
  assign rem_sh = {rem_r, q_r[WORD_BITS-1]};
  assign trial  = rem_sh - {1'b0, b_r};

  logic is_div;
  assign is_div = (op_r == OP_DIV) || (op_r == OP_MOD);

  always_comb begin
    rem_nxt = rem_r;
    q_nxt   = q_r;
    acc_nxt = acc_r;
    if (is_div) begin
      // q_r holds the dividend shifting out at the top, quotient in at bottom
      if (!trial[WORD_BITS]) begin
        rem_nxt = trial[WORD_BITS-1:0];
        q_nxt   = {q_r[WORD_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[WORD_BITS-1:0];
        q_nxt   = {q_r[WORD_BITS-2:0], 1'b0};
      end
    end else begin
      // multiply, msb first: acc = 2*acc + (bit ? a : 0); b shifts through q_r
      acc_nxt = {acc_r[WORD_BITS-2:0], 1'b0} + (q_r[WORD_BITS-1] ? a_r : '0);
      q_nxt   = {q_r[WORD_BITS-2:0], 1'b0};
    end
  end

  assign stat.iterative = (op_r == OP_DIV || op_r == OP_MOD || op_r == OP_MUL)
                          && (|b_r);
  assign stat.last      = (cnt_r == CNT_W'(WORD_BITS - 1));

  // combinational results of every operation, registered at finish
  logic [WORD_BITS-1:0] r_w;
  logic                 c_w, dz_w;
  logic [WORD_BITS-1:0] sum, diff;
  logic                 eq, lt;
  assign sum  = a_r + b_r;
  assign diff = a_r - b_r;
  assign eq   = (a_r == b_r);
  assign lt   = (a_r < b_r);

  logic [CNT_W-1:0] blen;
  always_comb begin
    blen = '0;
    for (int i = 0; i < WORD_BITS; i++)
      if (a_r[i]) blen = CNT_W'(i + 1);
  end

  // shift amount is the trimmed b; WORD_BITS or more gives zero
  logic [WORD_BITS-1:0] shl_v, shr_v;
  logic                 sh_zero;
  assign sh_zero = (b_r >= WORD_BITS);
  assign shl_v   = sh_zero ? '0 : a_r << b_r[CNT_W-1:0];
  assign shr_v   = sh_zero ? '0 : a_r >> b_r[CNT_W-1:0];

  always_comb begin
    r_w  = '0;
    c_w  = 1'b0;
    dz_w = 1'b0;
    unique case (op_r)
      OP_AND:    r_w = a_r & b_r;
      OP_OR:     r_w = a_r | b_r;
      OP_XOR:    r_w = a_r ^ b_r;
      OP_NOT:    r_w = ~a_r;
      OP_SHL:    r_w = shl_v;
      OP_SHR:    r_w = shr_v;
      OP_ADD:    r_w = sum;
      OP_SUB:    r_w = diff;
      OP_MUL:    r_w = acc_r;
      OP_DIV:    begin r_w = (|b_r) ? q_r : '0;   dz_w = ~|b_r; end
      OP_MOD:    begin r_w = (|b_r) ? rem_r : '0; dz_w = ~|b_r; end
      OP_EQ:     c_w = eq;
      OP_NE:     c_w = ~eq;
      OP_GT:     c_w = ~eq & ~lt;
      OP_LT:     c_w = lt;
      OP_GE:     c_w = ~lt;
      OP_LE:     c_w = lt | eq;
      OP_BITLEN: r_w = WORD_BITS'(blen);
      default:   ;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r        <= in_opcode;
      a_r         <= in_a[WORD_BITS-1:0];
      b_r         <= in_b[WORD_BITS-1:0];
    end
    if (cmd.init) begin
      cnt_r <= '0;
      rem_r <= '0;
      acc_r <= '0;
      q_r   <= is_div ? a_r : b_r;
    end else if (cmd.step) begin
      cnt_r <= cnt_r + 1'b1;
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      acc_r <= acc_nxt;
    end
    if (cmd.finish) begin
      res_r <= OUT_W'(r_w);
      cmp_r <= c_w;
      dz_r  <= dz_w;
    end
  end

  assign res     = res_r;
  assign cmp_res = cmp_r;
  assign dz_res  = dz_r;

endmodule

/* rtl/wu256_ctrl.sv */
// Controller: sequences load, iteration and result strobe.
module wu256_ctrl
  import wu256_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output logic     done,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (start) state_nxt = ST_LOAD;
      ST_LOAD:   state_nxt = stat.iterative ? ST_ITER : ST_FINISH;
      ST_ITER:   if (stat.last) state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = ST_DONE;
      ST_DONE:   state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    unique case (state_r)
      ST_IDLE:   begin busy = 1'b0; cmd.load = start; end
      ST_LOAD:   cmd.init = 1'b1;
      ST_ITER:   cmd.step = 1'b1;
      ST_FINISH: cmd.finish = 1'b1;
      ST_DONE:   done = 1'b1;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

/* rtl/wide_uint256_alu_core.sv */
// Top level of the wide unsigned ALU.
//
// Usage: present in_opcode and the operand words with start high while busy
// is low; that edge takes the beat. busy stays high until the result has
// been shown. The result appears on out_res_w0..3, out_compare_true and
// out_div_by_zero for exactly one cycle, marked by out_valid; the receiver
// must take it then, it cannot stall the block.
// Sequence: for the single-step operations the controller passes through
// load, finish and done; multiply, divide and modulo with a nonzero b
// also run the step loop over WORD_BITS bits between load and finish,
// which handles one bit per cycle. busy drops the cycle after the result,
// so a new beat is taken only after the current result has been shown.
// Reset (rst_n low, synchronous) returns the controller to idle
// and drops out_valid; an operation in flight is abandoned.
module wide_uint256_alu_core
  import wu256_pkg::*;
#(
  parameter int unsigned WORD_BITS = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  logic [4:0]   in_opcode,
  input  logic [63:0]  in_a_w0, in_a_w1, in_a_w2, in_a_w3,
  input  logic [63:0]  in_b_w0, in_b_w1, in_b_w2, in_b_w3,
  output logic         out_valid,
  output logic [63:0]  out_res_w0, out_res_w1, out_res_w2, out_res_w3,
  output logic         out_compare_true,
  output logic         out_div_by_zero
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     done;
  logic [NLIMBS*LIMB_W-1:0] res;
  logic     cmp_res, dz_res;

  wu256_ctrl u_ctrl (
    .clk, .rst_n, .start, .busy, .done, .cmd, .stat
  );

  wu256_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk, .cmd, .stat, .in_opcode,
    .in_a({in_a_w3, in_a_w2, in_a_w1, in_a_w0}),
    .in_b({in_b_w3, in_b_w2, in_b_w1, in_b_w0}),
    .res, .cmp_res, .dz_res
  );

  assign out_valid        = done;
  assign out_res_w0       = res[63:0];
  assign out_res_w1       = res[127:64];
  assign out_res_w2       = res[191:128];
  assign out_res_w3       = res[255:192];
  assign out_compare_true = cmp_res;
  assign out_div_by_zero  = dz_res;

endmodule

/* rtl/wu256_checker.sv */
// Port-level checker for the wide unsigned ALU, bound to the top level.
module wu256_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [63:0] out_res_w0, out_res_w1, out_res_w2, out_res_w3,
  input logic        out_compare_true,
  input logic        out_div_by_zero
);

  // a beat taken makes the block busy next cycle
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted beat did not raise busy");

  // result strobe is a single cycle and frees the block after it
  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy) else $error("result strobe not single");

  // result shows only while busy
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");

  // compare and divide-by-zero flags exclude each other
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_compare_true && out_div_by_zero))
    else $error("both flags set");

  // divide by zero gives a zero result
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_by_zero |->
      (out_res_w0 | out_res_w1 | out_res_w2 | out_res_w3) == 64'd0)
    else $error("nonzero result on divide by zero");

endmodule

bind wide_uint256_alu_core wu256_checker u_wu256_checker (.*);
